/* src/nrp_pkg.sv */
// Shared types and constants for the GPRMC position parser.
package nrp_pkg;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_W     = 8'h57;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_POINT = 8'h2E;

    localparam logic [1:0] REG_STATUS    = 2'd0;
    localparam logic [1:0] REG_LATITUDE  = 2'd1;
    localparam logic [1:0] REG_LONGITUDE = 2'd2;
    localparam logic [1:0] REG_SPEED     = 2'd3;

    localparam logic [6:0] STATUS_COLUMN_RST    = 7'd18;
    localparam logic [6:0] LATITUDE_COLUMN_RST  = 7'd20;
    localparam logic [6:0] LONGITUDE_COLUMN_RST = 7'd32;
    localparam logic [6:0] SPEED_COLUMN_RST     = 7'd45;

    localparam logic [3:0] LAT_DEG_LEN  = 4'd2;
    localparam logic [3:0] LON_DEG_LEN  = 4'd3;
    localparam logic [3:0] MIN_LEN      = 4'd9;
    localparam logic [3:0] SPD_LEN      = 4'd4;
    localparam logic [3:0] LAT_MIN_OFS  = 4'd2;
    localparam logic [3:0] LON_MIN_OFS  = 4'd3;
    localparam logic [3:0] LAT_HEMI_OFS = 4'd10;
    localparam logic [3:0] LON_HEMI_OFS = 4'd11;

    localparam logic [13:0] DEG_IP_MAX = 14'd999;
    localparam logic [13:0] MIN_IP_MAX = 14'd99;
    localparam logic [13:0] SPD_IP_MAX = 14'd9999;
    localparam logic [2:0]  DEG_F_MAX  = 3'd2;
    localparam logic [2:0]  MIN_F_MAX  = 3'd4;
    localparam logic [2:0]  SPD_F_MAX  = 3'd3;

    typedef struct packed {
        logic [13:0] ipart;
        logic [13:0] fpart;
        logic [2:0]  fdig;
    } window_t;

    typedef struct packed {
        window_t    lat_deg;
        window_t    lat_min;
        window_t    lon_deg;
        window_t    lon_min;
        window_t    spd;
        logic       fix;
        logic [1:0] neg;
    } line_t;

endpackage

/* src/nrp_ifs.sv */
// Valid/ready stream interfaces for the character input and the fix result.
interface nrp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

interface nrp_fix_if;
    logic               valid;
    logic               ready;
    logic               fix_valid;
    logic signed [26:0] latitude;
    logic signed [30:0] longitude;
    logic [23:0]        speed;

    modport source (output valid, output fix_valid, output latitude, output longitude,
                    output speed, input ready);
    modport sink (input valid, input fix_valid, input latitude, input longitude,
                  input speed, output ready);
endinterface

/* src/nrp_window.sv */
// Decimal number parser for one fixed-position character window.
module nrp_window
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             feed,
    input  logic [7:0]       ch,
    input  logic [13:0]      ip_max,
    input  logic [2:0]       f_max,
    output nrp_pkg::window_t win
);
    import nrp_pkg::*;

    typedef enum logic [1:0] {MODE_INT, MODE_FRAC, MODE_STOP} mode_t;

    mode_t       mode_reg;
    logic [13:0] ipart_reg;
    logic [13:0] fpart_reg;
    logic [2:0]  fdig_reg;

    logic        is_digit;
    logic        is_point;
    logic [3:0]  digit;
    logic [17:0] ip_wide;
    logic [13:0] ipart_next;
    logic [17:0] fp_wide;
    logic [13:0] fpart_next;

    assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    assign is_point = (ch == CHAR_POINT);
    assign digit    = 4'(ch - CHAR_ZERO);

    assign ip_wide    = ({4'd0, ipart_reg} << 3) + ({4'd0, ipart_reg} << 1) + 18'(digit);
    assign ipart_next = (ip_wide > 18'(ip_max)) ? ip_max : ip_wide[13:0];
    assign fp_wide    = ({4'd0, fpart_reg} << 3) + ({4'd0, fpart_reg} << 1) + 18'(digit);
    assign fpart_next = fp_wide[13:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_INT;
            ipart_reg <= '0;
            fpart_reg <= '0;
            fdig_reg  <= '0;
        end
        else if (clear)
        begin
            mode_reg  <= MODE_INT;
            ipart_reg <= '0;
            fpart_reg <= '0;
            fdig_reg  <= '0;
        end
        else if (feed)
        begin
            unique case (mode_reg)
                MODE_INT:
                begin
                    if (is_digit)
                        ipart_reg <= ipart_next;
                    else if (is_point)
                        mode_reg <= MODE_FRAC;
                    else
                        mode_reg <= MODE_STOP;
                end
                MODE_FRAC:
                begin
                    if (is_digit)
                    begin
                        if (fdig_reg < f_max)
                        begin
                            fpart_reg <= fpart_next;
                            fdig_reg  <= fdig_reg + 3'd1;
                        end
                    end
                    else
                        mode_reg <= MODE_STOP;
                end
                default:
                begin
                    mode_reg <= MODE_STOP;
                end
            endcase
        end
    end

    assign win.ipart = ipart_reg;
    assign win.fpart = fpart_reg;
    assign win.fdig  = fdig_reg;

endmodule

/* src/nrp_convert.sv */
// Two-stage fixed-point conversion of the parsed windows into one fix word.
module nrp_convert
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  nrp_pkg::line_t line,
    output logic           in_ready,
    nrp_fix_if.source      fix_stream
);
    import nrp_pkg::*;

    localparam logic [29:0] DEG_UNIT      = 30'd600000;
    localparam logic [29:0] DEG_TENTH     = 30'd60000;
    localparam logic [29:0] DEG_HUNDREDTH = 30'd6000;
    localparam logic [19:0] MIN_UNIT      = 20'd10000;
    localparam logic [23:0] SPD_UNIT      = 24'd1000;

    function automatic logic [29:0] deg_units(input logic [9:0] ip, input logic [6:0] fp,
                                              input logic [2:0] fd);
        logic [29:0] frac;
        case (fd)
            3'd0:    frac = '0;
            3'd1:    frac = 30'(fp) * DEG_TENTH;
            default: frac = 30'(fp) * DEG_HUNDREDTH;
        endcase
        return 30'(ip) * DEG_UNIT + frac;
    endfunction

    function automatic logic [19:0] min_units(input logic [6:0] ip, input logic [13:0] fp,
                                              input logic [2:0] fd);
        logic [19:0] frac;
        case (fd)
            3'd0:    frac = '0;
            3'd1:    frac = 20'(fp) * 20'd1000;
            3'd2:    frac = 20'(fp) * 20'd100;
            3'd3:    frac = 20'(fp) * 20'd10;
            default: frac = 20'(fp);
        endcase
        return 20'(ip) * MIN_UNIT + frac;
    endfunction

    function automatic logic [23:0] spd_units(input logic [13:0] ip, input logic [9:0] fp,
                                              input logic [2:0] fd);
        logic [23:0] frac;
        case (fd)
            3'd0:    frac = '0;
            3'd1:    frac = 24'(fp) * 24'd100;
            3'd2:    frac = 24'(fp) * 24'd10;
            default: frac = 24'(fp);
        endcase
        return 24'(ip) * SPD_UNIT + frac;
    endfunction

    logic        s1_v_reg;
    logic [29:0] lat_deg_reg;
    logic [19:0] lat_min_reg;
    logic [29:0] lon_deg_reg;
    logic [19:0] lon_min_reg;
    logic [23:0] spd_reg;
    logic        fix_reg;
    logic [1:0]  neg_reg;

    logic               out_v_reg;
    logic               fix_out_reg;
    logic signed [26:0] lat_out_reg;
    logic signed [30:0] lon_out_reg;
    logic [23:0]        spd_out_reg;

    logic        out_adv;
    logic [26:0] lat_sum;
    logic [30:0] lon_sum;
    logic [26:0] lat_next;
    logic [30:0] lon_next;

    assign out_adv  = !out_v_reg || fix_stream.ready;
    assign in_ready = !s1_v_reg || out_adv;

    assign lat_sum  = lat_deg_reg[26:0] + 27'(lat_min_reg);
    assign lon_sum  = 31'(lon_deg_reg) + 31'(lon_min_reg);
    assign lat_next = neg_reg[0] ? (27'd0 - lat_sum) : lat_sum;
    assign lon_next = neg_reg[1] ? (31'd0 - lon_sum) : lon_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_v_reg <= start;
            if (out_adv)
                out_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && in_ready)
        begin
            lat_deg_reg <= deg_units(line.lat_deg.ipart[9:0], line.lat_deg.fpart[6:0],
                                     line.lat_deg.fdig);
            lat_min_reg <= min_units(line.lat_min.ipart[6:0], line.lat_min.fpart,
                                     line.lat_min.fdig);
            lon_deg_reg <= deg_units(line.lon_deg.ipart[9:0], line.lon_deg.fpart[6:0],
                                     line.lon_deg.fdig);
            lon_min_reg <= min_units(line.lon_min.ipart[6:0], line.lon_min.fpart,
                                     line.lon_min.fdig);
            spd_reg     <= spd_units(line.spd.ipart, line.spd.fpart[9:0], line.spd.fdig);
            fix_reg     <= line.fix;
            neg_reg     <= line.neg;
        end
        if (out_adv && s1_v_reg)
        begin
            fix_out_reg <= fix_reg;
            lat_out_reg <= $signed(lat_next);
            lon_out_reg <= $signed(lon_next);
            spd_out_reg <= spd_reg;
        end
    end

    assign fix_stream.valid     = out_v_reg;
    assign fix_stream.fix_valid = fix_out_reg;
    assign fix_stream.latitude  = lat_out_reg;
    assign fix_stream.longitude = lon_out_reg;
    assign fix_stream.speed     = spd_out_reg;

`ifndef SYNTHESIS
    a_start_fills: assert property (@(posedge clk) disable iff (!rst_n)
        start && in_ready |=> s1_v_reg)
        else $error("accepted line end did not fill the conversion stage");
    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(s1_v_reg))
        else $error("result word appeared without a converted line");
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> spd_out_reg <= 24'd9999000)
        else $error("speed out of range");
    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (lat_out_reg <= 27'sd60399999) && (lat_out_reg >= -27'sd60399999))
        else $error("latitude out of range");
`endif

endmodule

/* src/nmea_rmc_position_parser.sv */
// Top level of the GPRMC position parser: column tracking, windows, config port.
//
// The char_stream sink takes one sentence character per word (valid/ready).
// Each character is parsed in the cycle it is accepted, so a new word can be
// taken every clock cycle while ready is high. Carriage return is ignored;
// newline closes the line. For each newline one word leaves on the fix_stream
// source: fix_valid, signed latitude and longitude in 0.0001 arc-minute units,
// and speed in 0.001 knot units. After the newline is accepted, the result
// passes through a conversion register and an output register.
// When the receiver stalls, the output register holds its word and the
// conversion register can still take one more line end; character words
// keep flowing until both are full, then ready drops.
// The APB port sets the columns of the status, latitude, longitude and speed
// fields; write it only while no line is in flight. Reset loads the default
// columns (18, 20, 32, 45), empties both registers and starts a new line.
// The column counter saturates at MAX_LINE; later characters are not parsed.
module nmea_rmc_position_parser
#(
    parameter int MAX_LINE = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    nrp_char_if.sink    char_stream,
    nrp_fix_if.source   fix_stream,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nrp_pkg::*;

    localparam int CW = $clog2(MAX_LINE + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    function automatic logic in_win(input logic [PW-1:0] col, input logic [PW-1:0] start,
                                    input logic [3:0] len);
        return (col >= start) && ((col - start) < PW'(len));
    endfunction

    logic [6:0]    status_col_reg;
    logic [6:0]    lat_col_reg;
    logic [6:0]    lon_col_reg;
    logic [6:0]    spd_col_reg;
    logic [CW-1:0] column_reg;
    logic          status_ok_reg;
    logic [1:0]    neg_reg;

    logic          cfg_write;
    logic [1:0]    cfg_sel;
    logic          conv_ready;
    logic          take;
    logic          is_lf;
    logic          is_cr;
    logic          col_live;
    logic          parse;
    logic [PW-1:0] col_ext;
    logic [PW-1:0] lat_start;
    logic [PW-1:0] lon_start;
    logic          feed_lat_deg;
    logic          feed_lat_min;
    logic          feed_lon_deg;
    logic          feed_lon_min;
    logic          feed_spd;
    line_t         line;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_col_reg <= STATUS_COLUMN_RST;
            lat_col_reg    <= LATITUDE_COLUMN_RST;
            lon_col_reg    <= LONGITUDE_COLUMN_RST;
            spd_col_reg    <= SPEED_COLUMN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_STATUS:    status_col_reg <= pwdata[6:0];
                REG_LATITUDE:  lat_col_reg    <= pwdata[6:0];
                REG_LONGITUDE: lon_col_reg    <= pwdata[6:0];
                REG_SPEED:     spd_col_reg    <= pwdata[6:0];
                default:       status_col_reg <= status_col_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_STATUS:    prdata = 32'(status_col_reg);
            REG_LATITUDE:  prdata = 32'(lat_col_reg);
            REG_LONGITUDE: prdata = 32'(lon_col_reg);
            REG_SPEED:     prdata = 32'(spd_col_reg);
            default:       prdata = '0;
        endcase
    end

    assign char_stream.ready = conv_ready;
    assign take     = char_stream.valid && char_stream.ready;
    assign is_lf    = (char_stream.char_in == CHAR_LF);
    assign is_cr    = (char_stream.char_in == CHAR_CR);
    assign col_live = (column_reg != CW'(MAX_LINE));
    assign parse    = take && !is_lf && !is_cr && col_live;

    assign col_ext   = PW'(column_reg);
    assign lat_start = PW'(lat_col_reg);
    assign lon_start = PW'(lon_col_reg);

    assign feed_lat_deg = parse && in_win(col_ext, lat_start, LAT_DEG_LEN);
    assign feed_lat_min = parse && in_win(col_ext, lat_start + PW'(LAT_MIN_OFS), MIN_LEN);
    assign feed_lon_deg = parse && in_win(col_ext, lon_start, LON_DEG_LEN);
    assign feed_lon_min = parse && in_win(col_ext, lon_start + PW'(LON_MIN_OFS), MIN_LEN);
    assign feed_spd     = parse && in_win(col_ext, PW'(spd_col_reg), SPD_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            status_ok_reg <= 1'b0;
            neg_reg       <= '0;
        end
        else if (take && is_lf)
        begin
            column_reg    <= '0;
            status_ok_reg <= 1'b0;
            neg_reg       <= '0;
        end
        else if (parse)
        begin
            column_reg <= column_reg + CW'(1);
            if (col_ext == PW'(status_col_reg))
                status_ok_reg <= (char_stream.char_in == CHAR_A);
            if (col_ext == lat_start + PW'(LAT_HEMI_OFS))
                neg_reg[0] <= (char_stream.char_in == CHAR_S);
            if (col_ext == lon_start + PW'(LON_HEMI_OFS))
                neg_reg[1] <= (char_stream.char_in == CHAR_W);
        end
    end

    nrp_window u_lat_deg
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (take && is_lf),
        .feed   (feed_lat_deg),
        .ch     (char_stream.char_in),
        .ip_max (DEG_IP_MAX),
        .f_max  (DEG_F_MAX),
        .win    (line.lat_deg)
    );

    nrp_window u_lat_min
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (take && is_lf),
        .feed   (feed_lat_min),
        .ch     (char_stream.char_in),
        .ip_max (MIN_IP_MAX),
        .f_max  (MIN_F_MAX),
        .win    (line.lat_min)
    );

    nrp_window u_lon_deg
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (take && is_lf),
        .feed   (feed_lon_deg),
        .ch     (char_stream.char_in),
        .ip_max (DEG_IP_MAX),
        .f_max  (DEG_F_MAX),
        .win    (line.lon_deg)
    );

    nrp_window u_lon_min
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (take && is_lf),
        .feed   (feed_lon_min),
        .ch     (char_stream.char_in),
        .ip_max (MIN_IP_MAX),
        .f_max  (MIN_F_MAX),
        .win    (line.lon_min)
    );

    nrp_window u_spd
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (take && is_lf),
        .feed   (feed_spd),
        .ch     (char_stream.char_in),
        .ip_max (SPD_IP_MAX),
        .f_max  (SPD_F_MAX),
        .win    (line.spd)
    );

    assign line.fix = status_ok_reg;
    assign line.neg = neg_reg;

    nrp_convert u_convert
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (take && is_lf),
        .line       (line),
        .in_ready   (conv_ready),
        .fix_stream (fix_stream)
    );

endmodule

/* dv/nmea_rmc_position_parser_tb.sv */
// Self-checking testbench for the GPRMC position parser: sentence stimulus and fix prediction.
`timescale 1ns / 100ps

module nmea_rmc_position_parser_tb;
    import nrp_pkg::*;

    localparam int LINE_LIMIT  = 128;
    localparam int DIR_ROWS    = 10;
    localparam int ITEM_TARGET = 1350;
    localparam int SETTLE      = 4;
    localparam int QUIET_LIMIT = 2000;

    typedef enum logic [1:0] {SCAN_INT, SCAN_FRAC, SCAN_DONE} scan_t;

    typedef struct packed {
        scan_t       mode;
        logic [31:0] whole;
        logic [31:0] frac;
        logic [2:0]  ndig;
    } decimal_t;

    typedef struct packed {
        logic               fix_valid;
        logic signed [26:0] latitude;
        logic signed [30:0] longitude;
        logic [23:0]        speed;
    } fix_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    nrp_char_if char_if ();
    nrp_fix_if  fix_if ();

    nmea_rmc_position_parser #(
        .MAX_LINE    (LINE_LIMIT)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_if),
        .fix_stream  (fix_if),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #6 clk = ~clk;

    logic [6:0] col_status;
    logic [6:0] col_lat;
    logic [6:0] col_lon;
    logic [6:0] col_spd;
    int         line_col;
    logic       fix_seen;
    logic [1:0] hemi_neg;
    decimal_t   lat_deg;
    decimal_t   lat_min;
    decimal_t   lon_deg;
    decimal_t   lon_min;
    decimal_t   spd_acc;

    fix_word_t  expected_fixes[$];
    logic [7:0] line_q[$];
    int         mismatches = 0;
    int         fixes_sent = 0;
    bit         typed_pending = 1'b0;
    fix_word_t  typed_fix;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;
    int         rx_hold = 0;

    string      dir_text [DIR_ROWS];
    int         dir_pad [DIR_ROWS];
    bit         dir_typed [DIR_ROWS];
    fix_word_t  dir_fix [DIR_ROWS];

    function automatic void start_new_line();
        line_col = 0;
        fix_seen = 1'b0;
        hemi_neg = 2'b00;
        lat_deg  = '0;
        lat_min  = '0;
        lon_deg  = '0;
        lon_min  = '0;
        spd_acc  = '0;
    endfunction

    function automatic decimal_t feed_decimal(decimal_t d, logic [7:0] ch, int col, int first,
                                              int len, int whole_max, int frac_max);
        if (col < first || col >= first + len || d.mode == SCAN_DONE)
            return d;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
        begin
            if (d.mode == SCAN_INT)
            begin
                d.whole = d.whole * 10 + 32'(ch - CHAR_ZERO);
                if (d.whole > 32'(whole_max))
                    d.whole = 32'(whole_max);
            end
            else if (int'(d.ndig) < frac_max)
            begin
                d.frac = d.frac * 10 + 32'(ch - CHAR_ZERO);
                d.ndig = d.ndig + 3'd1;
            end
        end
        else if (ch == CHAR_POINT && d.mode == SCAN_INT)
            d.mode = SCAN_FRAC;
        else
            d.mode = SCAN_DONE;
        return d;
    endfunction

    function automatic logic [31:0] arcmin_units(decimal_t deg, decimal_t mins);
        logic [31:0] deg_step;
        logic [31:0] min_step;
        case (deg.ndig)
            3'd0:    deg_step = 32'd0;
            3'd1:    deg_step = 32'd60000;
            default: deg_step = 32'd6000;
        endcase
        case (mins.ndig)
            3'd0:    min_step = 32'd0;
            3'd1:    min_step = 32'd1000;
            3'd2:    min_step = 32'd100;
            3'd3:    min_step = 32'd10;
            default: min_step = 32'd1;
        endcase
        return deg.whole * 600000 + deg.frac * deg_step + mins.whole * 10000
               + mins.frac * min_step;
    endfunction

    function automatic bit parse_char(input logic [7:0] ch, output fix_word_t word);
        int          col;
        logic [31:0] lat_mag;
        logic [31:0] lon_mag;
        logic [31:0] spd_step;
        logic [31:0] spd_val;
        word = '0;
        if (ch == CHAR_CR)
            return 1'b0;
        if (ch == CHAR_LF)
        begin
            lat_mag = arcmin_units(lat_deg, lat_min);
            lon_mag = arcmin_units(lon_deg, lon_min);
            if (hemi_neg[0])
                lat_mag = 32'd0 - lat_mag;
            if (hemi_neg[1])
                lon_mag = 32'd0 - lon_mag;
            case (spd_acc.ndig)
                3'd0:    spd_step = 32'd0;
                3'd1:    spd_step = 32'd100;
                3'd2:    spd_step = 32'd10;
                default: spd_step = 32'd1;
            endcase
            spd_val = spd_acc.whole * 1000 + spd_acc.frac * spd_step;
            word.fix_valid = fix_seen;
            word.latitude  = lat_mag[26:0];
            word.longitude = lon_mag[30:0];
            word.speed     = spd_val[23:0];
            start_new_line();
            return 1'b1;
        end
        if (line_col < LINE_LIMIT)
        begin
            col = line_col;
            if (col == int'(col_status))
                fix_seen = (ch == CHAR_A);
            if (col == int'(col_lat) + int'(LAT_HEMI_OFS))
                hemi_neg[0] = (ch == CHAR_S);
            if (col == int'(col_lon) + int'(LON_HEMI_OFS))
                hemi_neg[1] = (ch == CHAR_W);
            lat_deg = feed_decimal(lat_deg, ch, col, int'(col_lat), int'(LAT_DEG_LEN),
                                   int'(DEG_IP_MAX), int'(DEG_F_MAX));
            lat_min = feed_decimal(lat_min, ch, col, int'(col_lat) + int'(LAT_MIN_OFS),
                                   int'(MIN_LEN), int'(MIN_IP_MAX), int'(MIN_F_MAX));
            lon_deg = feed_decimal(lon_deg, ch, col, int'(col_lon), int'(LON_DEG_LEN),
                                   int'(DEG_IP_MAX), int'(DEG_F_MAX));
            lon_min = feed_decimal(lon_min, ch, col, int'(col_lon) + int'(LON_MIN_OFS),
                                   int'(MIN_LEN), int'(MIN_IP_MAX), int'(MIN_F_MAX));
            spd_acc = feed_decimal(spd_acc, ch, col, int'(col_spd), int'(SPD_LEN),
                                   int'(SPD_IP_MAX), int'(SPD_F_MAX));
            line_col++;
        end
        return 1'b0;
    endfunction

    function automatic int wait_length(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    task automatic send_char(input logic [7:0] ch);
        int        gap;
        fix_word_t word;
        gap = wait_length(tx_calm);
        if (gap > 0)
        begin
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_if.valid   <= 1'b1;
        char_if.char_in <= ch;
        @(posedge clk);
        while (!char_if.ready)
            @(posedge clk);
        if (parse_char(ch, word))
        begin
            expected_fixes.push_back(typed_pending ? typed_fix : word);
            fixes_sent++;
        end
    endtask

    task automatic drain_fixes();
        char_if.valid <= 1'b0;
        while (expected_fixes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_column(input logic [1:0] idx, input logic [6:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {25'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_STATUS:    col_status = value;
            REG_LATITUDE:  col_lat = value;
            REG_LONGITUDE: col_lon = value;
            default:       col_spd = value;
        endcase
        @(posedge clk);
    endtask

    task automatic put_char(input int col, input logic [7:0] ch);
        if (col >= 0 && col < line_q.size())
            line_q[col] = ch;
    endtask

    task automatic place_decimal(input int col, input int full_int, input int full_frac);
        int  shape;
        int  nint;
        int  nfrac;
        int  pos;
        bit  point;
        bit  nines;
        shape = $urandom_range(0, 9);
        nines = ($urandom_range(0, 7) == 0);
        pos   = col;
        if (shape < 6)
        begin
            nint  = full_int;
            point = (full_frac > 0);
            nfrac = full_frac;
        end
        else
        begin
            nint  = $urandom_range(0, full_int + 1);
            point = $urandom_range(0, 1);
            nfrac = $urandom_range(0, full_frac + 2);
        end
        if (shape == 9)
        begin
            case ($urandom_range(0, 3))
                0:       put_char(pos, "-");
                1:       put_char(pos, " ");
                2:       put_char(pos, "e");
                default: put_char(pos, 8'($urandom_range(0, 255)));
            endcase
            pos++;
        end
        repeat (nint)
        begin
            put_char(pos, nines ? CHAR_NINE : CHAR_ZERO + 8'($urandom_range(0, 9)));
            pos++;
        end
        if (point)
        begin
            put_char(pos, CHAR_POINT);
            pos++;
        end
        repeat (nfrac)
        begin
            put_char(pos, nines ? CHAR_NINE : CHAR_ZERO + 8'($urandom_range(0, 9)));
            pos++;
        end
        put_char(pos, ",");
    endtask

    task automatic compose_sentence();
        int r;
        int need;
        int len;
        line_q.delete();
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            repeat ($urandom_range(0, 20))
                line_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            need = int'(col_status) + 1;
            if (int'(col_lat) + 11 > need)
                need = int'(col_lat) + 11;
            if (int'(col_lon) + 12 > need)
                need = int'(col_lon) + 12;
            if (int'(col_spd) + 4 > need)
                need = int'(col_spd) + 4;
            if (r < 18)
                len = $urandom_range(0, need);
            else if (r < 24)
                len = $urandom_range(LINE_LIMIT, LINE_LIMIT + 22);
            else
                len = need + $urandom_range(0, 12);
            if (len > LINE_LIMIT + 22)
                len = LINE_LIMIT + 22;
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 3))
                    0, 1:    line_q.push_back(",");
                    2:       line_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                    default: line_q.push_back("G");
                endcase
            end
            put_char(0, "$");
            r = $urandom_range(0, 9);
            put_char(int'(col_status), r < 7 ? CHAR_A : r < 9 ? 8'("V") :
                     8'($urandom_range(0, 255)));
            place_decimal(int'(col_lat), 2, 0);
            place_decimal(int'(col_lat) + int'(LAT_MIN_OFS), 2, 4);
            put_char(int'(col_lat) + int'(LAT_HEMI_OFS), $urandom_range(0, 1) ? CHAR_S : 8'("N"));
            place_decimal(int'(col_lon), 3, 0);
            place_decimal(int'(col_lon) + int'(LON_MIN_OFS), 2, 4);
            put_char(int'(col_lon) + int'(LON_HEMI_OFS), $urandom_range(0, 1) ? CHAR_W : 8'("E"));
            place_decimal(int'(col_spd), 3, 1);
            if (line_q.size() > 0 && $urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end
        if ($urandom_range(0, 3) == 0)
            line_q.insert($urandom_range(0, line_q.size()), CHAR_CR);
        line_q.push_back(CHAR_LF);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            fix_if.ready <= 1'b0;
        else
        begin
            if ($urandom_range(0, 199) == 0)
                rx_calm = !rx_calm;
            if (rx_hold > 0)
            begin
                rx_hold--;
                fix_if.ready <= 1'b0;
            end
            else
            begin
                fix_if.ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 2) == 0)
                    rx_hold = wait_length(1'b0) + 1;
            end
        end
    end

    always @(posedge clk)
    begin : fix_check
        fix_word_t want;
        if (rst_n && fix_if.valid && fix_if.ready)
        begin
            if (expected_fixes.size() == 0)
            begin
                $error("fix word arrived with none expected");
                mismatches++;
            end
            else
            begin
                want = expected_fixes.pop_front();
                if (fix_if.fix_valid !== want.fix_valid)
                begin
                    $error("fix_valid: expected %0d, got %0d", want.fix_valid, fix_if.fix_valid);
                    mismatches++;
                end
                if (fix_if.latitude !== want.latitude)
                begin
                    $error("latitude: expected %0d, got %0d", want.latitude, fix_if.latitude);
                    mismatches++;
                end
                if (fix_if.longitude !== want.longitude)
                begin
                    $error("longitude: expected %0d, got %0d", want.longitude, fix_if.longitude);
                    mismatches++;
                end
                if (fix_if.speed !== want.speed)
                begin
                    $error("speed: expected %0d, got %0d", want.speed, fix_if.speed);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((char_if.valid && char_if.ready) || (fix_if.valid && fix_if.ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int         items;
        int         phase;
        int         lines_left;
        int         base;
        logic [6:0] s_col;
        logic [6:0] la_col;
        logic [6:0] lo_col;
        logic [6:0] sp_col;

        rst_n           = 1'b0;
        char_if.valid   = 1'b0;
        char_if.char_in = 8'h00;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 4'h0;
        pwdata          = 32'h0;
        col_status      = STATUS_COLUMN_RST;
        col_lat         = LATITUDE_COLUMN_RST;
        col_lon         = LONGITUDE_COLUMN_RST;
        col_spd         = SPEED_COLUMN_RST;
        start_new_line();

        // Rows at the reset columns; some carry a hand-worked fix word.
        dir_text[0] = "";
        dir_text[1] = "$GPRMC,123519.000,A,4807.0380,N,01131.0000,E,022.4,084.4,230394,003.1,W*6A";
        dir_text[2] = "$GPRMC,235959.999,A,9999.9999,S,99999.9999,W,9999,360.0,010101,,,A*00";
        dir_text[3] = "$GPRMC,000000.000,V,0000.0000,N,00000.0000,E,0000";
        dir_text[4] = "$GPRMC,101010.000,A,.512.345678,5.507.123456,.125,0.0*00";
        dir_text[5] = "$GPRMC,101010.000,A,12345.678,S,-12 34.5,W,W,1e30";
        dir_text[6] = "$GPRMC,123519.000,A,48\01507.0380,N,01131.0000,E,022.4\015";
        dir_text[7] = "$GPRMC,12";
        dir_text[8] = "$GPRMC,123519.000,V,4807.0380,S,01131.0000,W,022.4";
        dir_text[9] = "$GPRMC,123519.000,A,N4807.038,N,E01131.000,E,+22.";
        foreach (dir_pad[i])
        begin
            dir_pad[i]   = 0;
            dir_typed[i] = 1'b0;
            dir_fix[i]   = '0;
        end
        dir_pad[1]   = 100;
        dir_typed[0] = 1'b1;
        dir_typed[2] = 1'b1;
        dir_fix[2]   = '{1'b1, -27'sd60399999, -31'sd600399999, 24'd9999000};
        dir_typed[3] = 1'b1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        items = 0;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            for (int j = 0; j < dir_text[i].len(); j++)
            begin
                send_char(8'(dir_text[i].getc(j)));
                items++;
            end
            repeat (dir_pad[i])
            begin
                send_char(CHAR_NINE);
                items++;
            end
            typed_pending = dir_typed[i];
            typed_fix     = dir_fix[i];
            send_char(CHAR_LF);
            items++;
            typed_pending = 1'b0;
        end

        phase      = 0;
        lines_left = $urandom_range(4, 8);
        while (items < ITEM_TARGET)
        begin
            if (lines_left == 0)
            begin
                phase++;
                drain_fixes();
                case (phase % 6)
                    1:
                    begin
                        s_col = 7'd0; la_col = 7'd0; lo_col = 7'd0; sp_col = 7'd0;
                    end
                    2:
                    begin
                        s_col = 7'd127; la_col = 7'd127; lo_col = 7'd127; sp_col = 7'd127;
                    end
                    3:
                    begin
                        s_col = 7'd0; la_col = 7'd1; lo_col = 7'd12; sp_col = 7'd24;
                    end
                    4:
                    begin
                        s_col  = STATUS_COLUMN_RST;
                        la_col = LATITUDE_COLUMN_RST;
                        lo_col = LONGITUDE_COLUMN_RST;
                        sp_col = SPEED_COLUMN_RST;
                    end
                    5:
                    begin
                        s_col  = 7'($urandom_range(0, 127));
                        la_col = 7'($urandom_range(0, 127));
                        lo_col = 7'($urandom_range(0, 127));
                        sp_col = 7'($urandom_range(0, 127));
                    end
                    default:
                    begin
                        base   = $urandom_range(0, 100);
                        s_col  = 7'(base + $urandom_range(0, 20));
                        la_col = 7'(base + $urandom_range(0, 6));
                        lo_col = 7'(base + $urandom_range(0, 12));
                        sp_col = 7'(base + $urandom_range(0, 20));
                    end
                endcase
                write_column(REG_STATUS, s_col);
                write_column(REG_LATITUDE, la_col);
                write_column(REG_LONGITUDE, lo_col);
                write_column(REG_SPEED, sp_col);
                lines_left = (phase % 6 == 2) ? $urandom_range(2, 3) : $urandom_range(4, 9);
            end
            tx_calm = ($urandom_range(0, 4) == 0);
            compose_sentence();
            foreach (line_q[k])
            begin
                send_char(line_q[k]);
                if (line_q[k] != CHAR_CR)
                    items++;
            end
            lines_left--;
            if ($urandom_range(0, 9) == 0)
                drain_fixes();
        end

        drain_fixes();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
